// File: rtl/assert_macros.svh
// Assertion macros used by the sine impulse generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/sig_pkg.sv
// Package with the constants and types of the sine impulse generator.
package sig_pkg;

    localparam int LEN_W      = 13;
    localparam int MAX_LENGTH = 4096;
    localparam int AMP_W      = 16;
    localparam int FRAC_W     = 17;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 2;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;

    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 46;
    localparam int CNT_W     = 6;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_FRACTION = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_NEXT = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // Operation that the arithmetic unit has just finished.
    typedef enum logic [3:0] {
        OP_ZTEST,
        OP_DEN,
        OP_PHASE,
        OP_Y,
        OP_Y2,
        OP_D72,
        OP_M42,
        OP_D42,
        OP_M20,
        OP_D20,
        OP_M6,
        OP_D6,
        OP_S,
        OP_MAG
    } op_t;

endpackage

// File: rtl/sine_impulse_generator.sv
// Sine impulse generator: position control, serial multiplier and divider, sequencer.
//
// Each input beat on the s_ channel is one tick; s_tdata[0] is start_req and
// restarts the pulse at sample zero. Every tick yields exactly one output beat
// on the m_ channel: m_tdata holds the signed sample, m_tlast marks the final
// sample of the pulse and m_tuser[0] is high while a pulse is being emitted.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata, by the user
// only while idle; the block itself does not enforce this.
//
// All arithmetic runs through one shift-add multiplier (one bit per cycle) and
// one restoring divider (one quotient bit per cycle). A sample inside the pulse
// needs nine products and five quotients; a sample in the zero region at the
// pulse edges needs only the first product, and an idle tick none. The block
// works on one tick at a time; the next input beat is taken as soon as the
// sequencer is idle.
//
// The finished result sits in an output register, so a stalled receiver does
// not stop the next tick from being accepted and computed; only the hand-over
// into the output register waits for m_tready. Reset restores the register
// defaults, clears position and running state and empties the output.
module sine_impulse_generator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] start_req, [7:1] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [15:0] sample
    output logic                            m_tlast,
    output logic [0:0]                      m_tuser,   // [0] active
    input  logic                            cfg_wr_en,
    input  logic [sig_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sig_pkg::CFG_W-1:0]       cfg_wdata
);

`include "assert_macros.svh"

    localparam int LW = sig_pkg::LEN_W;
    localparam int CNT_W_L = sig_pkg::CNT_W;

    // Configuration registers.
    logic [LW-1:0]                 pl_reg;
    logic [sig_pkg::AMP_W-1:0]     amp_reg;
    logic [sig_pkg::FRAC_W-1:0]    wf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pl_reg  <= LW'(256);
            amp_reg <= 16'h7FFF;
            wf_reg  <= 17'h10000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sig_pkg::REG_PULSE_LENGTH:   pl_reg  <= cfg_wdata[LW-1:0];
                sig_pkg::REG_AMPLITUDE:      amp_reg <= cfg_wdata[15:0];
                sig_pkg::REG_WIDTH_FRACTION: wf_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective length: zero counts as one, long pulses are capped.
    logic [LW-1:0] len_eff;
    always_comb begin
        if (pl_reg == '0) begin
            len_eff = LW'(1);
        end else if (pl_reg > LW'(sig_pkg::MAX_LENGTH)) begin
            len_eff = LW'(sig_pkg::MAX_LENGTH);
        end else begin
            len_eff = pl_reg;
        end
    end

    sig_pkg::state_t state_reg, state_next;
    sig_pkg::op_t    op_reg, op_next;

    logic [LW-1:0] position_reg, position_next;
    logic          running_reg, running_next;

    logic s_fire;
    assign s_tready = (state_reg == sig_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Tick decode from the current position.
    logic [LW-1:0] pos_w, half_w, m_w;
    logic          run_w, last_w;
    always_comb begin
        pos_w  = s_tdata[0] ? '0 : position_reg;
        run_w  = s_tdata[0] | running_reg;
        if (run_w && (pos_w >= len_eff)) begin
            run_w = 1'b0;
        end
        half_w = len_eff >> 1;
        m_w    = (pos_w <= half_w) ? pos_w : LW'((half_w << 1) - pos_w);
        last_w = (pos_w == LW'(len_eff - LW'(1)));
    end

    // Working registers of the sample computation.
    logic [LW-1:0]  m_reg, m_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [16:0]    f_reg, f_next;
    logic [31:0]    y_reg, y_next;
    logic [31:0]    y2_reg, y2_next;
    logic [CNT_W_L-1:0] cnt_reg, cnt_next;

    // Serial multiplier operands and accumulator.
    logic [31:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [63:0] acc_reg, acc_next;
    // Serial divider: remainder, divisor, dividend shifted into quotient.
    logic [29:0] rem_reg, rem_next;
    logic [29:0] dv_reg, dv_next;
    logic [45:0] dq_reg, dq_next;

    // Result and output registers.
    logic [15:0] smp_reg, smp_next;
    logic        last_reg, last_next;
    logic        act_reg, act_next;
    logic        ov_reg, ov_next;
    logic [15:0] osmp_reg, osmp_next;
    logic        olast_reg, olast_next;
    logic        oact_reg, oact_next;

    assign m_tvalid   = ov_reg;
    assign m_tdata    = osmp_reg;
    assign m_tlast    = olast_reg;
    assign m_tuser[0] = oact_reg;

    // Datapath helpers.
    logic [32:0] msum;
    logic [30:0] trial;
    logic        dge;
    logic        f_full;
    logic [16:0] p_w, x_w;
    logic [31:0] t_w;
    logic [15:0] a_mag;
    logic [63:0] rnd_w;
    logic [33:0] r_w;

    always_comb begin
        msum   = {1'b0, acc_reg[63:32]} + (mb_reg[0] ? {1'b0, ma_reg} : 33'd0);
        trial  = {rem_reg, dq_reg[45]};
        dge    = (trial >= {1'b0, dv_reg});
        f_full = (f_reg >= 17'h10000);
        p_w    = ((|dq_reg[45:17]) || (dq_reg[16:0] > 17'h10000)) ? 17'h10000 : dq_reg[16:0];
        x_w    = (p_w > 17'h08000) ? 17'(17'h10000 - p_w) : p_w;
        t_w    = sig_pkg::ONE_Q30 - dq_reg[31:0];
        a_mag  = amp_reg[15] ? 16'(-amp_reg) : amp_reg;
        rnd_w  = acc_reg + 64'h0000_0000_2000_0000;
        r_w    = rnd_w[63:30];
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        position_next = position_reg;
        running_next  = running_reg;
        m_next        = m_reg;
        len_next      = len_reg;
        f_next        = f_reg;
        y_next        = y_reg;
        y2_next       = y2_reg;
        cnt_next      = cnt_reg;
        ma_next       = ma_reg;
        mb_next       = mb_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        dv_next       = dv_reg;
        dq_next       = dq_reg;
        smp_next      = smp_reg;
        last_next     = last_reg;
        act_next      = act_reg;
        ov_next       = ov_reg;
        osmp_next     = osmp_reg;
        olast_next    = olast_reg;
        oact_next     = oact_reg;

        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            sig_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (!run_w) begin
                        position_next = pos_w;
                        running_next  = 1'b0;
                        smp_next      = '0;
                        last_next     = 1'b0;
                        act_next      = 1'b0;
                        state_next    = sig_pkg::ST_DONE;
                    end else begin
                        position_next = LW'(pos_w + LW'(1));
                        running_next  = !last_w;
                        last_next     = last_w;
                        act_next      = 1'b1;
                        m_next        = m_w;
                        len_next      = len_eff;
                        f_next        = (wf_reg == '0) ? 17'h10000 : wf_reg;
                        // First product: len * (1 - F), for the zero-region test.
                        ma_next       = 32'(len_eff);
                        mb_next       = '0;
                        if (wf_reg < 17'h10000 && wf_reg != '0) begin
                            mb_next = 32'(17'h10000 - wf_reg);
                        end
                        acc_next      = '0;
                        cnt_next      = '0;
                        op_next       = sig_pkg::OP_ZTEST;
                        state_next    = sig_pkg::ST_MUL;
                    end
                end
            end
            sig_pkg::ST_MUL: begin
                acc_next = {msum, acc_reg[31:1]};
                mb_next  = mb_reg >> 1;
                cnt_next = CNT_W_L'(cnt_reg + CNT_W_L'(1));
                if (cnt_reg == CNT_W_L'(sig_pkg::MUL_STEPS - 1)) begin
                    state_next = sig_pkg::ST_NEXT;
                end
            end
            sig_pkg::ST_DIV: begin
                rem_next = dge ? 30'(trial - {1'b0, dv_reg}) : trial[29:0];
                dq_next  = {dq_reg[44:0], dge};
                cnt_next = CNT_W_L'(cnt_reg + CNT_W_L'(1));
                if (cnt_reg == CNT_W_L'(sig_pkg::DIV_STEPS - 1)) begin
                    state_next = sig_pkg::ST_NEXT;
                end
            end
            sig_pkg::ST_NEXT: begin
                cnt_next = '0;
                acc_next = '0;
                rem_next = '0;
                unique case (op_reg)
                    sig_pkg::OP_ZTEST: begin
                        if (!f_full && ({m_reg, 17'd0} < acc_reg[29:0])) begin
                            smp_next   = '0;
                            state_next = sig_pkg::ST_DONE;
                        end else begin
                            ma_next    = 32'(len_reg);
                            mb_next    = 32'(18'h10000 + 18'(f_reg));
                            op_next    = sig_pkg::OP_DEN;
                            state_next = sig_pkg::ST_MUL;
                        end
                    end
                    sig_pkg::OP_DEN: begin
                        dv_next    = acc_reg[29:0];
                        dq_next    = {m_reg, 33'd0} + 46'(acc_reg[29:1]);
                        op_next    = sig_pkg::OP_PHASE;
                        state_next = sig_pkg::ST_DIV;
                    end
                    sig_pkg::OP_PHASE: begin
                        ma_next    = 32'(x_w);
                        mb_next    = sig_pkg::PI_Q30;
                        op_next    = sig_pkg::OP_Y;
                        state_next = sig_pkg::ST_MUL;
                    end
                    sig_pkg::OP_Y: begin
                        y_next     = acc_reg[47:16];
                        ma_next    = acc_reg[47:16];
                        mb_next    = acc_reg[47:16];
                        op_next    = sig_pkg::OP_Y2;
                        state_next = sig_pkg::ST_MUL;
                    end
                    sig_pkg::OP_Y2: begin
                        y2_next    = acc_reg[61:30];
                        dq_next    = 46'(acc_reg[61:30]);
                        dv_next    = 30'd72;
                        op_next    = sig_pkg::OP_D72;
                        state_next = sig_pkg::ST_DIV;
                    end
                    sig_pkg::OP_D72, sig_pkg::OP_D42, sig_pkg::OP_D20: begin
                        ma_next    = y2_reg;
                        mb_next    = t_w;
                        state_next = sig_pkg::ST_MUL;
                        if (op_reg == sig_pkg::OP_D72) begin
                            op_next = sig_pkg::OP_M42;
                        end else if (op_reg == sig_pkg::OP_D42) begin
                            op_next = sig_pkg::OP_M20;
                        end else begin
                            op_next = sig_pkg::OP_M6;
                        end
                    end
                    sig_pkg::OP_M42, sig_pkg::OP_M20, sig_pkg::OP_M6: begin
                        dq_next    = 46'(acc_reg[61:30]);
                        state_next = sig_pkg::ST_DIV;
                        if (op_reg == sig_pkg::OP_M42) begin
                            dv_next = 30'd42;
                            op_next = sig_pkg::OP_D42;
                        end else if (op_reg == sig_pkg::OP_M20) begin
                            dv_next = 30'd20;
                            op_next = sig_pkg::OP_D20;
                        end else begin
                            dv_next = 30'd6;
                            op_next = sig_pkg::OP_D6;
                        end
                    end
                    sig_pkg::OP_D6: begin
                        ma_next    = y_reg;
                        mb_next    = t_w;
                        op_next    = sig_pkg::OP_S;
                        state_next = sig_pkg::ST_MUL;
                    end
                    sig_pkg::OP_S: begin
                        ma_next    = 32'(a_mag);
                        mb_next    = acc_reg[61:30];
                        op_next    = sig_pkg::OP_MAG;
                        state_next = sig_pkg::ST_MUL;
                    end
                    sig_pkg::OP_MAG: begin
                        // Round half away from zero, restore the sign, saturate.
                        if (amp_reg[15]) begin
                            smp_next = (r_w > 34'd32768) ? 16'h8000 : 16'(~r_w[15:0] + 16'd1);
                        end else begin
                            smp_next = (r_w > 34'd32767) ? 16'h7FFF : r_w[15:0];
                        end
                        state_next = sig_pkg::ST_DONE;
                    end
                    default: begin
                        state_next = sig_pkg::ST_DONE;
                    end
                endcase
            end
            sig_pkg::ST_DONE: begin
                if (!ov_reg || m_tready) begin
                    ov_next    = 1'b1;
                    osmp_next  = smp_reg;
                    olast_next = last_reg;
                    oact_next  = act_reg;
                    state_next = sig_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sig_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sig_pkg::ST_IDLE;
            op_reg       <= sig_pkg::OP_ZTEST;
            position_reg <= '0;
            running_reg  <= 1'b0;
            ov_reg       <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            position_reg <= position_next;
            running_reg  <= running_next;
            ov_reg       <= ov_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg     <= m_next;
        len_reg   <= len_next;
        f_reg     <= f_next;
        y_reg     <= y_next;
        y2_reg    <= y2_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        dv_reg    <= dv_next;
        dq_reg    <= dq_next;
        smp_reg   <= smp_next;
        last_reg  <= last_next;
        act_reg   <= act_next;
        osmp_reg  <= osmp_next;
        olast_reg <= olast_next;
        oact_reg  <= oact_next;
    end

    // An idle tick goes straight to the hand-over with an inactive result.
    `ASSERT_NEXT(a_idle_tick, aclk, aresetn, s_fire && !s_tdata[0] && !running_reg, state_reg == sig_pkg::ST_DONE && !act_reg)
    // An inactive beat carries a zero sample and no last flag.
    `ASSERT_IMPLY(a_inactive_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 16'd0 && !m_tlast)
    // The final sample of a pulse always belongs to an active pulse.
    `ASSERT_IMPLY(a_last_active, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0])

endmodule

// File: sim/tb_sine_impulse_generator.sv
// Self-checking testbench for the sine impulse generator with a bit-exact sample predictor.
module tb_sine_impulse_generator;
    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog limit, STALL_LIMIT, is set well above both the slowest tick
    // and the long receiver hold-off of HOLD_CYCLES.
    localparam int HOLD_CYCLES = 3000;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 600;
    localparam int RANDOM_TICKS = 1550;
    localparam int CLEAN_TICKS = 100;
    localparam int CFG_W_L = sig_pkg::CFG_W;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        logic               active;
    } tick_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = '0;     // [0] start_req, [7:1] zero
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [15:0]                    m_tdata;          // [15:0] sample
    logic                           m_tlast;
    logic [0:0]                     m_tuser;          // [0] active
    logic                           cfg_wr_en = 1'b0;
    logic [sig_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sig_pkg::CFG_W-1:0]      cfg_wdata = '0;

    sine_impulse_generator dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predictor state: a private copy of the registers, position and run flag.
    logic [12:0]        len_reg = 13'd256;
    logic signed [15:0] amp_reg = 16'sd32767;
    logic [16:0]        frac_reg = 17'd65536;
    logic [12:0]        pos = '0;
    bit                 running = 1'b0;

    tick_result_t expected_ticks[$];
    int  ticks_sent = 0;
    int  mismatches = 0;
    bit  idling_on = 1'b1;
    int  hold_rx = 0;

    // Sine of pi*p/65536 in Q30: folded phase, Horner series, products and
    // divisions all truncated.
    function automatic longint sine_q30(input longint p);
        longint x, y, y2, t;
        x  = (p > 32768) ? 65536 - p : p;
        y  = (x * longint'(sig_pkg::PI_Q30)) >>> 16;
        y2 = (y * y) >>> 30;
        t  = longint'(sig_pkg::ONE_Q30) - y2 / 72;
        t  = longint'(sig_pkg::ONE_Q30) - ((y2 * t) >>> 30) / 42;
        t  = longint'(sig_pkg::ONE_Q30) - ((y2 * t) >>> 30) / 20;
        t  = longint'(sig_pkg::ONE_Q30) - ((y2 * t) >>> 30) / 6;
        return (y * t) >>> 30;
    endfunction

    function automatic logic signed [15:0] pulse_sample(input longint p, input longint len);
        longint h, m, f, num, den, ph, s, a, r, v;
        h = len / 2;
        m = (p <= h) ? p : 2 * h - p;
        f = (frac_reg == 0) ? 65536 : longint'(frac_reg);
        // Below the offset the pulse is flat zero; the test is done exactly.
        if (m * 131072 < len * (65536 - f))
            return '0;
        num = m << 33;
        den = len * (65536 + f);
        ph  = (num + den / 2) / den;
        if (ph > 65536)
            ph = 65536;
        s = sine_q30(ph);
        a = (amp_reg < 0) ? -longint'(amp_reg) : longint'(amp_reg);
        r = (a * s + (longint'(1) << 29)) >>> 30;
        v = (amp_reg < 0) ? -r : r;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic tick_result_t advance_tick(input bit start);
        longint       len;
        tick_result_t r;
        len = (len_reg == 0) ? 1 : ((len_reg > sig_pkg::MAX_LENGTH) ?
              longint'(sig_pkg::MAX_LENGTH) : longint'(len_reg));
        r = '0;
        if (start) begin
            pos = '0;
            running = 1'b1;
        end
        // A shorter length written mid-pulse ends the pulse on this tick.
        if (running && pos >= len)
            running = 1'b0;
        if (!running)
            return r;
        r.sample = pulse_sample(pos, len);
        r.last   = (pos == len - 1);
        r.active = 1'b1;
        pos = pos + 1'b1;
        if (r.last)
            running = 1'b0;
        return r;
    endfunction

    // Send one tick. Valid stays high into the next call unless a gap is drawn.
    task automatic send_tick(input bit start);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, start};
        do @(posedge aclk); while (!s_tready);
        expected_ticks.push_back(advance_tick(start));
        ticks_sent++;
        @(negedge aclk);
    endtask

    // Waits until every outstanding tick has come back and the block is quiet.
    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_ticks.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [sig_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sig_pkg::CFG_W-1:0] value);
        drain();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        unique case (idx)
            sig_pkg::REG_PULSE_LENGTH:   len_reg = value[12:0];
            sig_pkg::REG_AMPLITUDE:      amp_reg = value[15:0];
            sig_pkg::REG_WIDTH_FRACTION: frac_reg = value[16:0];
            default: ;
        endcase
    endtask

    task automatic set_pulse(input int len, input int amp, input int frac);
        write_reg(sig_pkg::REG_PULSE_LENGTH, CFG_W_L'(len));
        write_reg(sig_pkg::REG_AMPLITUDE, CFG_W_L'(amp & 32'h0000_FFFF));
        write_reg(sig_pkg::REG_WIDTH_FRACTION, CFG_W_L'(frac));
    endtask

    // Start a pulse, then send plain ticks; those past its end show the idle ticks too.
    task automatic run_pulse(input int ticks);
        send_tick(1'b1);
        repeat (ticks - 1) send_tick(1'b0);
    endtask

    // Directed corners: idle ticks, length clamps, even and odd centers,
    // amplitude and width-fraction extremes, and a length change mid-pulse.
    task automatic test_corners();
        send_tick(1'b0);
        set_pulse(0, 32767, 0);
        run_pulse(2);
        set_pulse(2, -32768, 65536);
        run_pulse(3);
        set_pulse(4, 32767, 131071);
        run_pulse(5);
        set_pulse(5, -32768, 1);
        run_pulse(6);
        set_pulse(8191, 12345, 32768);
        run_pulse(3);
        // The position is now past the new length, so the pulse stops.
        write_reg(sig_pkg::REG_PULSE_LENGTH, CFG_W_L'(2));
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    // Random settings followed by mostly well-formed pulses with stray starts.
    task automatic test_random_pulses();
        int len, frac, ticks, sel;
        while (ticks_sent < RANDOM_TICKS) begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                len = $urandom_range(0, 24);
            else if (sel < 9)
                len = $urandom_range(25, 200);
            else
                len = $urandom_range(201, 8191);
            case ($urandom_range(0, 4))
                0: frac = 0;
                1: frac = 65536;
                2: frac = $urandom_range(65537, 131071);
                default: frac = $urandom_range(1, 65535);
            endcase
            set_pulse(len, int'($urandom), frac);
            ticks = (len > 200) ? $urandom_range(2, 8) : len + $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0) begin
                // Noise: starts and plain ticks at random.
                repeat ($urandom_range(3, 12)) send_tick(1'($urandom_range(0, 1)));
            end else begin
                send_tick(1'b1);
                repeat (ticks) send_tick($urandom_range(0, 11) == 0);
            end
        end
    endtask

    // The receiver holds off for a long stretch while ticks keep coming,
    // so the output register fills and the input side must stall.
    task automatic test_backpressure();
        set_pulse(6, -20000, 40000);
        hold_rx = HOLD_CYCLES;
        run_pulse(8);
    endtask

    // The closing part runs with no idling on either side.
    task automatic test_back_to_back();
        set_pulse(12, 30000, 0);
        idling_on = 1'b0;
        repeat (CLEAN_TICKS / 14) run_pulse(14);
    endtask

    // Receiver readiness changes at the falling edge.
    int rx_gap = 0;
    always @(negedge aclk) begin
        if (hold_rx > 0) begin
            m_tready <= 1'b0;
            hold_rx  <= hold_rx - 1;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            rx_gap   <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every result beat is checked against the oldest expected tick.
    always @(posedge aclk) begin
        tick_result_t exp_r, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata, m_tlast, m_tuser[0]};
            if (expected_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: sample %0d last %b active %b",
                             got.sample, got.last, got.active);
            end else begin
                exp_r = expected_ticks.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d/%b/%b got %0d/%b/%b",
                                 exp_r.sample, exp_r.last, exp_r.active,
                                 got.sample, got.last, got.active);
                end
            end
        end
    end

    // The watchdog counts cycles in which no beat moves on either side.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[sine_impulse_generator] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_corners();
        test_backpressure();
        test_random_pulses();
        test_back_to_back();
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_ticks.size() == 0)
            $display("[sine_impulse_generator] OK");
        else
            $display("[sine_impulse_generator] ERROR");
        $finish;
    end

endmodule

// File: sine_impulse_generator.f
+incdir+rtl
rtl/sig_pkg.sv
rtl/sine_impulse_generator.sv
sim/tb_sine_impulse_generator.sv
